>>> sv/ggc_pkg.sv
package ggc_pkg;

   localparam int MAX_VERTICES_DEFAULT = 64;

   localparam int CMD_W    = 2;
   localparam int VERTEX_W = 6;
   localparam int COLOR_W  = 6;
   localparam int COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COLOR = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [VERTEX_W-1:0] from_vertex;
      logic [VERTEX_W-1:0] to_vertex;
      logic [COUNT_W-1:0]  vertex_count;
   } ggc_req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [COLOR_W-1:0]  color;
      logic                last;
   } ggc_rsp_type;

   typedef enum logic [1:0] {
      ROW_SEL_FROM,
      ROW_SEL_TO,
      ROW_SEL_VERTEX
   } row_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        clear_rows;
      row_sel_type row_sel;
      logic        row_rd;
      logic        row_wr;
      logic        vtx_start;
      logic        scan_step;
      logic        find_step;
      logic        emit;
   } ggc_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic color_found;
      logic out_free;
      logic last_vertex;
   } ggc_status_type;

endpackage

>>> sv/ggc_ctrl.sv
module ggc_ctrl #(
   parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ggc_pkg::ggc_req_type   req_data,
   input  ggc_pkg::ggc_status_type status,
   output ggc_pkg::ggc_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE_RD_A,
      ST_EDGE_WR_A,
      ST_EDGE_RD_B,
      ST_EDGE_WR_B,
      ST_VTX_RD,
      ST_SCAN,
      ST_FIND
   } state_type;

   localparam logic [ggc_pkg::COUNT_W-1:0] MAX_COUNT = ggc_pkg::COUNT_W'(MAX_VERTICES);

   state_type state_ff;
   state_type state_in;
   logic      edge_ok;
   logic      count_zero;

   assign edge_ok = ({1'b0, req_data.from_vertex} < MAX_COUNT) &&
                    ({1'b0, req_data.to_vertex} < MAX_COUNT);
   assign count_zero = (req_data.vertex_count == '0);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.row_sel = ggc_pkg::ROW_SEL_FROM;
      req_ready   = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               unique case (req_data.cmd)
                  ggc_pkg::CMD_CLEAR: begin
                     cmd.clear_rows = 1'b1;
                  end
                  ggc_pkg::CMD_EDGE: begin
                     if (edge_ok) begin
                        state_in = ST_EDGE_RD_A;
                     end
                  end
                  ggc_pkg::CMD_COLOR: begin
                     if (!count_zero) begin
                        state_in = ST_VTX_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EDGE_RD_A: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_EDGE_WR_A;
         end
         ST_EDGE_WR_A: begin
            cmd.row_wr = 1'b1;
            state_in   = ST_EDGE_RD_B;
         end
         ST_EDGE_RD_B: begin
            cmd.row_sel = ggc_pkg::ROW_SEL_TO;
            cmd.row_rd  = 1'b1;
            state_in    = ST_EDGE_WR_B;
         end
         ST_EDGE_WR_B: begin
            cmd.row_sel = ggc_pkg::ROW_SEL_TO;
            cmd.row_wr  = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_VTX_RD: begin
            cmd.row_sel   = ggc_pkg::ROW_SEL_VERTEX;
            cmd.row_rd    = 1'b1;
            cmd.vtx_start = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            if (!status.color_found) begin
               cmd.find_step = 1'b1;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.last_vertex ? ST_IDLE : ST_VTX_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/ggc_datapath.sv
module ggc_datapath #(
   parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ggc_pkg::ggc_req_type    req_data,
   input  ggc_pkg::ggc_cmd_type    cmd,
   output ggc_pkg::ggc_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ggc_pkg::ggc_rsp_type    rsp_data
);

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
   localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);
   localparam logic [ggc_pkg::COUNT_W-1:0] MAX_COUNT = ggc_pkg::COUNT_W'(MAX_VERTICES);
   localparam logic [VIDX_W-1:0] LAST_COLOR = VIDX_W'(MAX_VERTICES - 1);

   logic [VIDX_W-1:0]       from_ff;
   logic [VIDX_W-1:0]       to_ff;
   logic [VCNT_W-1:0]       count_ff;
   logic [VCNT_W-1:0]       count_in;
   logic [VIDX_W-1:0]       v_ff;
   logic [VIDX_W-1:0]       u_ff;
   logic [VIDX_W-1:0]       c_ff;
   logic                    pend_ff;
   logic [MAX_VERTICES-1:0] used_ff;

   logic [MAX_VERTICES-1:0] adj_ram_ff [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] adj_q_ff;
   logic                    adj_valid_q_ff;
   logic [MAX_VERTICES-1:0] row_valid_ff;

   logic [VIDX_W-1:0]       col_ram_ff [MAX_VERTICES];
   logic [VIDX_W-1:0]       col_q_ff;

   logic                    rsp_valid_ff;
   ggc_pkg::ggc_rsp_type    rsp_ff;

   logic [VIDX_W-1:0]       row_addr;
   logic [VIDX_W-1:0]       other_vertex;
   logic [MAX_VERTICES-1:0] adj_row;
   logic [MAX_VERTICES-1:0] row_wdata;
   logic                    scan_more;

   always_comb begin
      unique case (cmd.row_sel)
         ggc_pkg::ROW_SEL_FROM: begin
            row_addr     = from_ff;
            other_vertex = to_ff;
         end
         ggc_pkg::ROW_SEL_TO: begin
            row_addr     = to_ff;
            other_vertex = from_ff;
         end
         ggc_pkg::ROW_SEL_VERTEX: begin
            row_addr     = v_ff;
            other_vertex = from_ff;
         end
         default: begin
            row_addr     = from_ff;
            other_vertex = to_ff;
         end
      endcase
   end

   // rows never written since the last clear read as empty
   assign adj_row   = adj_valid_q_ff ? adj_q_ff : '0;
   assign row_wdata = adj_row | (ROW_ONE << other_vertex);
   assign scan_more = (u_ff != v_ff);
   assign count_in  = (req_data.vertex_count > MAX_COUNT) ? VCNT_W'(MAX_VERTICES)
                                                         : VCNT_W'(req_data.vertex_count);

   assign status.scan_done   = !scan_more && !pend_ff;
   assign status.color_found = !used_ff[c_ff] || (c_ff == LAST_COLOR);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign status.last_vertex = ((VCNT_W'(v_ff) + VCNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         from_ff  <= req_data.from_vertex[VIDX_W-1:0];
         to_ff    <= req_data.to_vertex[VIDX_W-1:0];
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_wr) begin
         adj_ram_ff[row_addr] <= row_wdata;
      end
      if (cmd.row_rd) begin
         adj_q_ff <= adj_ram_ff[row_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff   <= '0;
         adj_valid_q_ff <= 1'b0;
      end else begin
         if (cmd.clear_rows) begin
            row_valid_ff <= '0;
         end else if (cmd.row_wr) begin
            row_valid_ff[row_addr] <= 1'b1;
         end
         if (cmd.row_rd) begin
            adj_valid_q_ff <= row_valid_ff[row_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         col_ram_ff[v_ff] <= c_ff;
      end
      if (cmd.scan_step && scan_more) begin
         col_q_ff <= col_ram_ff[u_ff];
      end
   end

   // neighbour scan over lower vertices, then lowest free colour search
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         v_ff <= '0;
      end else if (cmd.emit && !status.last_vertex) begin
         v_ff <= v_ff + VIDX_W'(1);
      end
      if (cmd.vtx_start) begin
         u_ff    <= '0;
         c_ff    <= '0;
         pend_ff <= 1'b0;
         used_ff <= '0;
      end else begin
         if (cmd.scan_step) begin
            if (scan_more) begin
               pend_ff <= adj_row[u_ff];
               u_ff    <= u_ff + VIDX_W'(1);
            end else begin
               pend_ff <= 1'b0;
            end
            if (pend_ff) begin
               used_ff <= used_ff | (ROW_ONE << col_q_ff);
            end
         end
         if (cmd.find_step) begin
            c_ff <= c_ff + VIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.vertex <= ggc_pkg::VERTEX_W'(v_ff);
         rsp_ff.color  <= ggc_pkg::COLOR_W'(c_ff);
         rsp_ff.last   <= status.last_vertex;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/greedy_graph_coloring_core.sv
// Greedy graph colouring. Edges are loaded into a symmetric adjacency matrix held in a
// memory with one valid bit per row, so a clear item only resets the valid bits and an
// add-edge item does a read-modify-write of each of the two rows through one port. A
// colour item with count n walks vertices 0 .. n-1 in order and gives each the lowest
// colour not held by a lower numbered neighbour. Each vertex first fetches its row, then
// looks up the colours of the lower vertices in the colour memory, and then tries colours
// from zero upward, the last try loading the result into the output register; that last
// step waits while the register still holds an item not yet taken.
// A count above MAX_VERTICES is taken as MAX_VERTICES; a count of zero gives nothing, like
// an unused command. Edges with an end at or above MAX_VERTICES are dropped. The final
// result is marked last, and a new item is taken once the previous one has loaded its last
// result into the output register.
module greedy_graph_coloring_core #(
   parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ggc_pkg::ggc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ggc_pkg::ggc_rsp_type rsp_data
);

   ggc_pkg::ggc_cmd_type    cmd;
   ggc_pkg::ggc_status_type status;

   ggc_ctrl #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .status    (status),
      .cmd       (cmd)
   );

   ggc_datapath #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_colour_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.color <= rsp_data.vertex))
      else $error("colour above vertex index");

   a_colour_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.cmd == ggc_pkg::CMD_COLOR) &&
       (req_data.vertex_count != '0)) |=> !req_ready)
      else $error("colour item did not hold off input");

   a_clear_single: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.cmd == ggc_pkg::CMD_CLEAR)) |=> req_ready)
      else $error("clear item did not finish in one cycle");

endmodule

>>> tb/sv/greedy_graph_coloring_core_test.sv
module greedy_graph_coloring_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VERTICES = ggc_pkg::MAX_VERTICES_DEFAULT;
   localparam int TOP_COLOR = (1 << ggc_pkg::COLOR_W) - 1;
   localparam logic [ggc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int SETTLE_CYCLES = 200;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   ggc_pkg::ggc_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   ggc_pkg::ggc_rsp_type rsp_data;

   ggc_pkg::ggc_req_type        pending_items[$];
   ggc_pkg::ggc_rsp_type        colors_due[$];
   ggc_pkg::ggc_rsp_type        oldest_due;
   logic [VERTICES-1:0]         adjacency[VERTICES] = '{default: '0};
   logic [ggc_pkg::COLOR_W-1:0] colors_given[VERTICES] = '{default: '0};

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic hold_start = 1'b0;
   int   hold_left = 0;
   bit   failed = 1'b0;

   greedy_graph_coloring_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // updates the graph and works out the colours that a colour item hands out
   function automatic void apply_graph_item(ggc_pkg::ggc_req_type item);
      int unsigned          count;
      int unsigned          pick;
      logic [VERTICES-1:0]  used;
      ggc_pkg::ggc_rsp_type due;
      case (item.cmd)
         ggc_pkg::CMD_CLEAR: begin
            foreach (adjacency[i]) adjacency[i] = '0;
         end
         ggc_pkg::CMD_EDGE: begin
            if (item.from_vertex < VERTICES && item.to_vertex < VERTICES) begin
               adjacency[item.from_vertex][item.to_vertex] = 1'b1;
               adjacency[item.to_vertex][item.from_vertex] = 1'b1;
            end
         end
         ggc_pkg::CMD_COLOR: begin
            count = (item.vertex_count > VERTICES) ? VERTICES : item.vertex_count;
            for (int v = 0; v < count; v++) begin
               used = '0;
               for (int u = 0; u < v; u++) begin
                  if (adjacency[v][u]) used[colors_given[u]] = 1'b1;
               end
               pick = 0;
               while (pick < TOP_COLOR && used[pick]) pick++;
               colors_given[v] = ggc_pkg::COLOR_W'(pick);
               due.vertex = ggc_pkg::VERTEX_W'(v);
               due.color = ggc_pkg::COLOR_W'(pick);
               due.last = (v + 1 == count);
               colors_due.push_back(due);
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) apply_graph_item(req_data);
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (colors_due.size() == 0) begin
               $display("%0t: unexpected item, vertex %0d colour %0d last %0d", $time,
                        rsp_data.vertex, rsp_data.color, rsp_data.last);
               failed = 1'b1;
            end else begin
               oldest_due = colors_due.pop_front();
               if (rsp_data.vertex !== oldest_due.vertex) begin
                  $display("%0t: vertex expected %0d, got %0d", $time,
                           oldest_due.vertex, rsp_data.vertex);
                  failed = 1'b1;
               end
               if (rsp_data.color !== oldest_due.color) begin
                  $display("%0t: colour of vertex %0d expected %0d, got %0d", $time,
                           oldest_due.vertex, oldest_due.color, rsp_data.color);
                  failed = 1'b1;
               end
               if (rsp_data.last !== oldest_due.last) begin
                  $display("%0t: last of vertex %0d expected %0d, got %0d", $time,
                           oldest_due.vertex, oldest_due.last, rsp_data.last);
                  failed = 1'b1;
               end
            end
         end
         rsp_ready <= hold_left == 0 && !hold_start && $urandom_range(99) >= recv_stall_pct;
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_OFF_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic push_item(logic [ggc_pkg::CMD_W-1:0] cmd, int unsigned a, int unsigned b,
                            int unsigned n);
      ggc_pkg::ggc_req_type item;
      item.cmd = cmd;
      item.from_vertex = ggc_pkg::VERTEX_W'(a);
      item.to_vertex = ggc_pkg::VERTEX_W'(b);
      item.vertex_count = ggc_pkg::COUNT_W'(n);
      pending_items.push_back(item);
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || colors_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic add_random_items(int unsigned amount);
      int unsigned made;
      int unsigned span;
      int unsigned count;
      int unsigned edges;
      int unsigned roll;
      int unsigned a;
      int unsigned b;
      logic [ggc_pkg::CMD_W-1:0] cmd;
      made = 0;
      while (made < amount) begin
         if ($urandom_range(99) < 12) begin
            // noise: any command, any fields
            cmd = ggc_pkg::CMD_W'($urandom_range(3));
            push_item(cmd, $urandom_range(63), $urandom_range(63), $urandom_range(127));
            if (cmd != CMD_UNUSED) made++;
         end else begin
            span = ($urandom_range(99) < 4) ? VERTICES : $urandom_range(16, 1);
            if ($urandom_range(9) < 7) begin
               push_item(ggc_pkg::CMD_CLEAR, $urandom_range(63), $urandom_range(63),
                         $urandom_range(127));
               made++;
            end
            if (span <= 16 && $urandom_range(11) == 0) begin
               // dense clique for high colours
               span = $urandom_range(10, 3);
               for (int i = 1; i < span; i++) begin
                  for (int j = 0; j < i; j++) begin
                     if ($urandom_range(1)) begin
                        push_item(ggc_pkg::CMD_EDGE, i, j, $urandom_range(127));
                     end else begin
                        push_item(ggc_pkg::CMD_EDGE, j, i, $urandom_range(127));
                     end
                     made++;
                  end
               end
            end else begin
               edges = $urandom_range(2 * span, 0);
               for (int i = 0; i < edges; i++) begin
                  a = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(span - 1);
                  b = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(span - 1);
                  push_item(ggc_pkg::CMD_EDGE, a, b, $urandom_range(127));
                  made++;
               end
            end
            roll = $urandom_range(99);
            if (span == VERTICES) count = $urandom_range(1) ? VERTICES : $urandom_range(127, 65);
            else if (roll < 5) count = 0;
            else if (roll < 20) count = $urandom_range(20, 1);
            else count = span;
            push_item(ggc_pkg::CMD_COLOR, $urandom_range(63), $urandom_range(63), count);
            made++;
            if ($urandom_range(15) == 0) wait_drained();
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_item(ggc_pkg::CMD_COLOR, 0, 0, 0);
      push_item(ggc_pkg::CMD_COLOR, 0, 0, 1);
      push_item(CMD_UNUSED, 63, 63, 127);
      push_item(ggc_pkg::CMD_EDGE, 1, 0, 0);
      push_item(ggc_pkg::CMD_EDGE, 2, 1, 0);
      push_item(ggc_pkg::CMD_EDGE, 0, 2, 0);
      push_item(ggc_pkg::CMD_EDGE, 3, 3, 0);
      push_item(ggc_pkg::CMD_EDGE, 3, 0, 0);
      push_item(ggc_pkg::CMD_EDGE, 0, 63, 0);
      push_item(ggc_pkg::CMD_EDGE, 63, 62, 127);
      push_item(ggc_pkg::CMD_EDGE, 1, 0, 0);
      push_item(ggc_pkg::CMD_COLOR, 0, 0, 127);
      push_item(ggc_pkg::CMD_COLOR, 63, 63, 4);
      push_item(ggc_pkg::CMD_CLEAR, 63, 63, 127);
      push_item(ggc_pkg::CMD_COLOR, 0, 0, 64);
      push_item(ggc_pkg::CMD_EDGE, 63, 63, 0);
      push_item(ggc_pkg::CMD_EDGE, 5, 4, 0);
      push_item(ggc_pkg::CMD_COLOR, 0, 0, 65);
      push_item(ggc_pkg::CMD_CLEAR, 0, 0, 0);
      push_item(ggc_pkg::CMD_COLOR, 0, 0, 2);
      wait_drained();

      // receiver holds off while the sender keeps offering items
      hold_start = 1'b1;
      @(negedge clock);
      hold_start = 1'b0;
      push_item(ggc_pkg::CMD_COLOR, 0, 0, 24);
      for (int i = 0; i < 12; i++) begin
         push_item(ggc_pkg::CMD_EDGE, $urandom_range(11), $urandom_range(11), 0);
      end
      push_item(ggc_pkg::CMD_COLOR, 0, 0, 12);
      wait_drained();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      add_random_items(103);
      wait_drained();
      send_idle_pct = 64;
      add_random_items(103);
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 64;
      add_random_items(103);
      wait_drained();
      send_idle_pct = 16;
      recv_stall_pct = 16;
      add_random_items(103);
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (!failed && colors_due.size() == 0) begin
         $display("greedy_graph_coloring_core_test OK");
      end else begin
         $display("greedy_graph_coloring_core_test NOT OK");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("%0t: timeout", $time);
      $display("greedy_graph_coloring_core_test NOT OK");
      $finish;
   end

endmodule
